// ===== hdl/rtg_pkg.sv =====
// Shared types, register codes and reset constants for the ramp/triangle generator.
`default_nettype none

package rtg_pkg;

  // Default number of fraction bits of the phase
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register field widths
  localparam int MODE_W     = 2;
  localparam int STEP_W     = 17;
  localparam int DWELL_W    = 16;
  localparam int MARGIN_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Input beat: advance in bit 0, zero padded to a byte
  localparam int IN_TDATA_W = 8;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_MODE       = 2'd0,
    CFG_STEP_SIZE       = 2'd1,
    CFG_DWELL_TICKS     = 2'd2,
    CFG_BOUNDARY_MARGIN = 2'd3
  } rtg_cfg_idx_t;

  // Step modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SINGLE     = 2'd0,
    MODE_REPEAT     = 2'd1,
    MODE_REVERSIBLE = 2'd2
  } rtg_mode_t;

  // Configuration register reset values
  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_SINGLE;
  localparam logic [STEP_W-1:0]   STEP_RST   = 17'd656;
  localparam logic [DWELL_W-1:0]  DWELL_RST  = 16'd0;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 8'd1;

  typedef struct packed {
    logic [MODE_W-1:0]   step_mode;
    logic [STEP_W-1:0]   step_size;
    logic [DWELL_W-1:0]  dwell_ticks;
    logic [MARGIN_W-1:0] boundary_margin;
  } rtg_cfg_t;

  // Direction and dwell control state
  typedef struct packed {
    logic               going_down;
    logic               dwell_started;
    logic [DWELL_W-1:0] dwell_remaining;
  } rtg_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/ramp_triangle_generator_with_dwell.sv =====
// Top level of the ramp/triangle phase accumulator with boundary dwell.
//
//   channel | direction | beat contents (low bit first)
//   --------+-----------+----------------------------------------------------
//   in_     | sink      | tdata: advance, zero pad to 8 bits
//   out_    | source    | tdata: t_value (FRAC_BITS+3), going_down, dwelling, pad
//   cfg_    | sink      | index 0..3, data: register value in low bits
//
// Every input beat yields exactly one output beat, registered in the cycle after
// acceptance; one beat per cycle is sustained while out_tready stays high, with the
// single output register holding the result until it is taken.
// in_tready drops only while a result waits and out_tready is low.
// rst_n is synchronous: it clears the phase, direction and dwell state, loads
// the register defaults and empties the output register. cfg_ready is always
// high; writes land on the next edge.
`default_nettype none

module ramp_triangle_generator_with_dwell #(
  parameter int FRAC_BITS = rtg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: [0] advance, [7:1] zero
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [rtg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: [FRAC_BITS+2:0] t_value, [FRAC_BITS+3] going_down,
  //            [FRAC_BITS+4] dwelling, rest zero
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [((FRAC_BITS+5+7)/8)*8-1:0]      out_tdata,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rtg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int PW   = FRAC_BITS + 3;
  localparam int OUTW = ((FRAC_BITS + 5 + 7) / 8) * 8;

  rtg_pkg::rtg_cfg_t cfg_r;
  rtg_pkg::rtg_ctl_t ctl_r;
  rtg_pkg::rtg_ctl_t ctl_nxt;
  logic [PW-1:0]     phase_r;
  logic [PW-1:0]     phase_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [OUTW-1:0]   out_data_r;
  logic              in_acc;

  // Accept whenever the output register is empty or being drained
  assign in_tready     = !out_valid_r || out_tready;
  assign in_acc        = in_tvalid && in_tready;
  assign out_valid_nxt = in_acc || (out_valid_r && !out_tready);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign cfg_ready     = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_mode       <= rtg_pkg::MODE_RST;
      cfg_r.step_size       <= rtg_pkg::STEP_RST;
      cfg_r.dwell_ticks     <= rtg_pkg::DWELL_RST;
      cfg_r.boundary_margin <= rtg_pkg::MARGIN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtg_pkg::CFG_STEP_MODE:
          cfg_r.step_mode <= cfg_data[rtg_pkg::MODE_W-1:0];
        rtg_pkg::CFG_STEP_SIZE:
          cfg_r.step_size <= cfg_data[rtg_pkg::STEP_W-1:0];
        rtg_pkg::CFG_DWELL_TICKS:
          cfg_r.dwell_ticks <= cfg_data[rtg_pkg::DWELL_W-1:0];
        rtg_pkg::CFG_BOUNDARY_MARGIN:
          cfg_r.boundary_margin <= cfg_data[rtg_pkg::MARGIN_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  rtg_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .advance   (in_tdata[0]),
    .cfg       (cfg_r),
    .phase     (phase_r),
    .ctl       (ctl_r),
    .phase_nxt (phase_nxt),
    .ctl_nxt   (ctl_nxt)
  );

  // Phase and control state advance only on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r <= phase_nxt;
        ctl_r   <= ctl_nxt;
      end
    end
  end

  // Result payload: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= OUTW'({ctl_nxt.dwell_started, ctl_nxt.going_down, phase_nxt});
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rtg_step.sv =====
// Combinational next-state logic for one tick of the phase accumulator.
`default_nettype none

module rtg_step #(
  parameter int FRAC_BITS = rtg_pkg::FRAC_BITS_DEF
) (
  input  wire logic                   advance,
  input  wire rtg_pkg::rtg_cfg_t      cfg,
  input  wire logic [FRAC_BITS+2:0]   phase,
  input  wire rtg_pkg::rtg_ctl_t      ctl,
  output logic      [FRAC_BITS+2:0]   phase_nxt,
  output rtg_pkg::rtg_ctl_t           ctl_nxt
);

  localparam int PW  = FRAC_BITS + 3;
  localparam int SW  = PW + 1;
  localparam int XW  = SW + rtg_pkg::STEP_W;
  localparam int LSH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int RSH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic signed [SW-1:0] PMAX = SW'((1 << (PW - 1)) - 1);
  localparam logic signed [SW-1:0] PMIN = -SW'(1 << (PW - 1));
  localparam logic signed [PW-1:0] ONE  = PW'(1 << FRAC_BITS);

  logic        [XW-1:0] step_ext;
  logic        [XW-1:0] step_sh;
  logic signed [SW-1:0] step_s;
  logic        [PW-1:0] eps_ext;
  logic signed [PW-1:0] eps;
  logic signed [PW-1:0] top;
  logic signed [PW-1:0] bottom;
  logic signed [SW-1:0] ph_ext;
  logic signed [SW-1:0] sum;
  logic signed [PW-1:0] moved;
  logic                 hit_top;
  logic                 hit_bottom;
  logic                 dwell_go;
  logic [rtg_pkg::DWELL_W-1:0] rem;

  // Rescale the Q1.16 step and Q0.16 margin register values to the phase's fraction width
  assign step_ext = {{(XW-rtg_pkg::STEP_W){1'b0}}, cfg.step_size};
  assign step_sh  = (step_ext >> RSH) << LSH;
  assign step_s   = $signed(step_sh[SW-1:0]);
  assign eps_ext  = {{(PW-rtg_pkg::MARGIN_W){1'b0}}, cfg.boundary_margin};
  assign eps      = $signed((eps_ext >> RSH) << LSH);
  assign top      = ONE + eps;
  assign bottom   = -eps;

  // Move by one step and saturate to the phase range
  assign ph_ext = {phase[PW-1], phase};
  assign sum    = ctl.going_down ? ph_ext - step_s : ph_ext + step_s;

  always_comb begin
    if (sum > PMAX) begin
      moved = PMAX[PW-1:0];
    end else if (sum < PMIN) begin
      moved = PMIN[PW-1:0];
    end else begin
      moved = sum[PW-1:0];
    end
  end

  assign hit_top    = moved > top;
  assign hit_bottom = moved < bottom;

  always_comb begin
    phase_nxt = phase;
    ctl_nxt   = ctl;
    dwell_go  = 1'b0;
    rem       = ctl.dwell_remaining;
    if (advance) begin
      case (cfg.step_mode)
        rtg_pkg::MODE_SINGLE: begin
          if ($signed(phase) <= top) begin
            phase_nxt = moved;
          end
        end
        rtg_pkg::MODE_REPEAT, rtg_pkg::MODE_REVERSIBLE: begin
          phase_nxt = moved;
          if (hit_top || (cfg.step_mode == rtg_pkg::MODE_REVERSIBLE && hit_bottom)) begin
            // Arm the dwell on the first boundary tick
            if (!ctl.dwell_started && cfg.dwell_ticks != '0) begin
              ctl_nxt.dwell_started = 1'b1;
              rem                   = cfg.dwell_ticks;
            end
            dwell_go = rem != '0;
            if (dwell_go) begin
              // Hold at the boundary while the count runs down
              ctl_nxt.dwell_remaining = rem - 1'b1;
              phase_nxt               = hit_top ? top : bottom;
            end else begin
              // Restart and pick the new direction
              ctl_nxt.dwell_remaining = rem;
              ctl_nxt.dwell_started   = 1'b0;
              if (hit_top && cfg.step_mode == rtg_pkg::MODE_REVERSIBLE) begin
                phase_nxt          = ONE;
                ctl_nxt.going_down = 1'b1;
              end else begin
                phase_nxt          = '0;
                ctl_nxt.going_down = 1'b0;
              end
            end
          end
        end
        default: begin
          phase_nxt = phase;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rtg_checker.sv =====
// Port-level checker for the ramp/triangle generator, bound to the top level.
`default_nettype none

module rtg_checker #(
  parameter int FRAC_BITS = rtg_pkg::FRAC_BITS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [((FRAC_BITS+5+7)/8)*8-1:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  // Every accepted beat shows a result on the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  // No input is taken while a result waits unaccepted
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted over a stalled result");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An idle cycle with no result pending leaves the output empty
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) && (!out_tvalid || out_tready) |=> !out_tvalid)
    else $error("result appeared with no accepted beat");

endmodule

bind ramp_triangle_generator_with_dwell rtg_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_rtg_checker (.*);

`default_nettype wire
